[hdl/ufm_pkg.sv]
// Shared types, widths and request codes of the union-find engine with element move.
package ufm_pkg;

    localparam int NUM_ELEMS = 1024;
    localparam int TBL_DEPTH = NUM_ELEMS + 1;
    localparam int NODE_W    = $clog2(TBL_DEPTH);
    localparam int TYPE_W    = 2;
    localparam int ELEM_W    = 11;
    localparam int SIZE_W    = 11;
    localparam int SUM_W     = 20;

    localparam logic [TYPE_W-1:0] REQ_JOIN  = 2'd0;
    localparam logic [TYPE_W-1:0] REQ_MOVE  = 2'd1;
    localparam logic [TYPE_W-1:0] REQ_QUERY = 2'd2;

    typedef logic [NODE_W-1:0] t_node;

    typedef struct packed {
        logic  we;
        t_node waddr;
        t_node wdata;
        t_node raddr;
    } t_node_req;

    typedef struct packed {
        logic              we;
        t_node             waddr;
        logic [SIZE_W-1:0] wdata;
        t_node             raddr;
    } t_size_req;

    typedef struct packed {
        logic             we;
        t_node            waddr;
        logic [SUM_W-1:0] wdata;
        t_node            raddr;
    } t_sum_req;

    typedef struct packed {
        logic [SUM_W-1:0]  set_sum;
        logic [SIZE_W-1:0] set_size;
    } t_result;

endpackage

[hdl/ufm_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module ufm_ram #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[hdl/ufm_alu.sv]
// Shared add/subtract unit used for every size and sum update.
module ufm_alu import ufm_pkg::*; (
    input  logic [SUM_W-1:0] i_op_a,
    input  logic [SUM_W-1:0] i_op_b,
    input  logic             i_sub,
    output logic [SUM_W-1:0] o_res
);

    always_comb begin
        if (i_sub) begin
            o_res = i_op_a - i_op_b;
        end else begin
            o_res = i_op_a + i_op_b;
        end
    end

endmodule

[hdl/ufm_core.sv]
// Sequencer: table clearing, root finds with path compression, joins, moves and queries.
module ufm_core import ufm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_req_valid,
    output logic              o_req_ready,
    input  logic [TYPE_W-1:0] i_req_type,
    input  logic [ELEM_W-1:0] i_elem_a,
    input  logic [ELEM_W-1:0] i_elem_b,
    output logic              o_res_valid,
    input  logic              i_res_ready,
    output t_result           o_res,
    output t_node_req         o_alias_req,
    input  t_node             i_alias_q,
    output t_node_req         o_parent_req,
    input  t_node             i_parent_q,
    output t_size_req         o_size_req,
    input  logic [SIZE_W-1:0] i_size_q,
    output t_sum_req          o_sum_req,
    input  logic [SUM_W-1:0]  i_sum_q
);

    typedef enum logic [11:0] {
        ST_CLEAR  = 12'b0000_0000_0001,
        ST_IDLE   = 12'b0000_0000_0010,
        ST_DECODE = 12'b0000_0000_0100,
        ST_FB     = 12'b0000_0000_1000,
        ST_FC     = 12'b0000_0001_0000,
        ST_PB     = 12'b0000_0010_0000,
        ST_FEND   = 12'b0000_0100_0000,
        ST_RDX    = 12'b0000_1000_0000,
        ST_RDY    = 12'b0001_0000_0000,
        ST_CAP    = 12'b0010_0000_0000,
        ST_WR     = 12'b0100_0000_0000,
        ST_QRY    = 12'b1000_0000_0000
    } t_state;

    t_state            r_state, n_state;
    t_node             r_clr, n_clr;
    logic [TYPE_W-1:0] r_type, n_type;
    logic [ELEM_W-1:0] r_a, n_a;
    logic [ELEM_W-1:0] r_b, n_b;
    logic              r_phase_b, n_phase_b;
    t_node             r_start, n_start;
    t_node             r_start_b, n_start_b;
    t_node             r_cur, n_cur;
    t_node             r_root, n_root;
    t_node             r_x, n_x;
    t_node             r_y, n_y;
    logic [SIZE_W-1:0] r_sx, n_sx;
    logic [SIZE_W-1:0] r_sy, n_sy;
    logic [SUM_W-1:0]  r_sumx, n_sumx;
    logic [SUM_W-1:0]  r_sumy, n_sumy;
    logic [1:0]        r_step, n_step;

    logic [SUM_W-1:0]  alu_a, alu_b, alu_res;
    logic              alu_sub;
    logic              a_ok, b_ok;

    ufm_alu u_alu (
        .i_op_a (alu_a),
        .i_op_b (alu_b),
        .i_sub  (alu_sub),
        .o_res  (alu_res)
    );

    assign a_ok = (r_a != '0) && (r_a <= ELEM_W'(NUM_ELEMS));
    assign b_ok = (r_b != '0) && (r_b <= ELEM_W'(NUM_ELEMS));

    assign o_req_ready = (r_state == ST_IDLE);
    assign o_res.set_size = i_size_q;
    assign o_res.set_sum  = i_sum_q;

    always_comb begin
        n_state   = r_state;
        n_clr     = r_clr;
        n_type    = r_type;
        n_a       = r_a;
        n_b       = r_b;
        n_phase_b = r_phase_b;
        n_start   = r_start;
        n_start_b = r_start_b;
        n_cur     = r_cur;
        n_root    = r_root;
        n_x       = r_x;
        n_y       = r_y;
        n_sx      = r_sx;
        n_sy      = r_sy;
        n_sumx    = r_sumx;
        n_sumy    = r_sumy;
        n_step    = r_step;

        o_alias_req  = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
        o_parent_req = '{we: 1'b0, waddr: '0, wdata: '0, raddr: '0};
        o_size_req   = '{we: 1'b0, waddr: '0, wdata: '0, raddr: r_x};
        o_sum_req    = '{we: 1'b0, waddr: '0, wdata: '0, raddr: r_x};
        o_res_valid  = 1'b0;
        alu_a        = '0;
        alu_b        = '0;
        alu_sub      = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // Every element starts as its own singleton set.
                o_alias_req  = '{we: 1'b1, waddr: r_clr, wdata: r_clr, raddr: '0};
                o_parent_req = '{we: 1'b1, waddr: r_clr, wdata: r_clr, raddr: '0};
                o_size_req   = '{we: 1'b1, waddr: r_clr, wdata: SIZE_W'(1), raddr: r_x};
                o_sum_req    = '{we: 1'b1, waddr: r_clr, wdata: SUM_W'(r_clr), raddr: r_x};
                n_clr = r_clr + 1'b1;
                if (r_clr == NODE_W'(TBL_DEPTH - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_req_valid) begin
                    n_type  = i_req_type;
                    n_a     = i_elem_a;
                    n_b     = i_elem_b;
                    n_state = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if (!a_ok || (r_type != REQ_JOIN && r_type != REQ_MOVE
                              && r_type != REQ_QUERY)) begin
                    n_state = ST_IDLE;
                end else if (r_type != REQ_QUERY && !b_ok) begin
                    n_state = ST_IDLE;
                end else begin
                    o_alias_req.raddr = NODE_W'(r_a);
                    n_phase_b = 1'b0;
                    n_state   = ST_FB;
                end
            end
            ST_FB: begin
                n_start = i_alias_q;
                if (r_phase_b) begin
                    n_start_b = i_alias_q;
                end
                o_parent_req.raddr = i_alias_q;
                n_cur   = i_alias_q;
                n_state = ST_FC;
            end
            ST_FC: begin
                if (i_parent_q == r_cur) begin
                    n_root = r_cur;
                    if (r_start == r_cur) begin
                        n_state = ST_FEND;
                    end else begin
                        o_parent_req.raddr = r_start;
                        n_cur   = r_start;
                        n_state = ST_PB;
                    end
                end else begin
                    o_parent_req.raddr = i_parent_q;
                    n_cur = i_parent_q;
                end
            end
            ST_PB: begin
                // Point the node at the root while fetching its old parent.
                o_parent_req.we    = 1'b1;
                o_parent_req.waddr = r_cur;
                o_parent_req.wdata = r_root;
                if (i_parent_q == r_root) begin
                    n_state = ST_FEND;
                end else begin
                    o_parent_req.raddr = i_parent_q;
                    n_cur = i_parent_q;
                end
            end
            ST_FEND: begin
                if (!r_phase_b) begin
                    n_x = r_root;
                    if (r_type == REQ_QUERY) begin
                        n_state = ST_RDX;
                    end else begin
                        o_alias_req.raddr = NODE_W'(r_b);
                        n_phase_b = 1'b1;
                        n_state   = ST_FB;
                    end
                end else begin
                    n_y = r_root;
                    if (r_root == r_x) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_state = ST_RDX;
                    end
                end
            end
            ST_RDX: begin
                if (r_type == REQ_QUERY) begin
                    n_state = ST_QRY;
                end else begin
                    n_state = ST_RDY;
                end
            end
            ST_RDY: begin
                o_size_req.raddr = r_y;
                o_sum_req.raddr  = r_y;
                n_sx    = i_size_q;
                n_sumx  = i_sum_q;
                n_state = ST_CAP;
            end
            ST_CAP: begin
                // For a join, x ends up as the root of the smaller set (a's root on a tie) and goes under y.
                if (r_type == REQ_JOIN && r_sx > i_size_q) begin
                    n_x    = r_y;
                    n_y    = r_x;
                    n_sx   = i_size_q;
                    n_sumx = i_sum_q;
                    n_sy   = r_sx;
                    n_sumy = r_sumx;
                end else begin
                    n_sy   = i_size_q;
                    n_sumy = i_sum_q;
                end
                n_step  = 2'd0;
                n_state = ST_WR;
            end
            ST_WR: begin
                n_step = r_step + 1'b1;
                if (r_type == REQ_JOIN) begin
                    if (r_step == 2'd0) begin
                        alu_a = SUM_W'(r_sx);
                        alu_b = SUM_W'(r_sy);
                        o_size_req.we    = 1'b1;
                        o_size_req.waddr = r_y;
                        o_size_req.wdata = alu_res[SIZE_W-1:0];
                        o_parent_req.we    = 1'b1;
                        o_parent_req.waddr = r_x;
                        o_parent_req.wdata = r_y;
                    end else begin
                        alu_a = r_sumx;
                        alu_b = r_sumy;
                        o_sum_req.we    = 1'b1;
                        o_sum_req.waddr = r_y;
                        o_sum_req.wdata = alu_res;
                        n_state = ST_IDLE;
                    end
                end else begin
                    unique case (r_step)
                        2'd0: begin
                            alu_a   = SUM_W'(r_sx);
                            alu_b   = SUM_W'(1);
                            alu_sub = 1'b1;
                            o_size_req.we    = 1'b1;
                            o_size_req.waddr = r_x;
                            o_size_req.wdata = alu_res[SIZE_W-1:0];
                            o_alias_req.we    = 1'b1;
                            o_alias_req.waddr = NODE_W'(r_a);
                            o_alias_req.wdata = r_start_b;
                        end
                        2'd1: begin
                            alu_a   = r_sumx;
                            alu_b   = SUM_W'(r_a);
                            alu_sub = 1'b1;
                            o_sum_req.we    = 1'b1;
                            o_sum_req.waddr = r_x;
                            o_sum_req.wdata = alu_res;
                        end
                        2'd2: begin
                            alu_a = SUM_W'(r_sy);
                            alu_b = SUM_W'(1);
                            o_size_req.we    = 1'b1;
                            o_size_req.waddr = r_y;
                            o_size_req.wdata = alu_res[SIZE_W-1:0];
                        end
                        default: begin
                            alu_a = r_sumy;
                            alu_b = SUM_W'(r_a);
                            o_sum_req.we    = 1'b1;
                            o_sum_req.waddr = r_y;
                            o_sum_req.wdata = alu_res;
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_QRY: begin
                o_res_valid = i_res_ready;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type    <= n_type;
        r_a       <= n_a;
        r_b       <= n_b;
        r_phase_b <= n_phase_b;
        r_start   <= n_start;
        r_start_b <= n_start_b;
        r_cur     <= n_cur;
        r_root    <= n_root;
        r_x       <= n_x;
        r_y       <= n_y;
        r_sx      <= n_sx;
        r_sy      <= n_sy;
        r_sumx    <= n_sumx;
        r_sumy    <= n_sumy;
        r_step    <= n_step;
    end

endmodule

[hdl/union_find_with_move_unit.sv]
// Top level of the union-find engine with element move: tables, sequencer, output register.
//
// Disjoint-set engine over elements 1..1024 with join, move and query requests. After
// reset the block sets every element up as a singleton and accepts no item meanwhile.
// It then takes one item at a time. The time per item is set by the parent-table walk,
// which reads one node per cycle through the single read port of the parent memory and
// then rewrites the path one node per cycle. A request with an element out of range
// (for a query only elem_a is checked) or an unknown type is dropped after decode, and
// a join or a move whose two elements are already in one set ends after the two root
// finds; neither gives a result. A query result sits in an output register, so the next
// item is taken while it waits to be read.
module union_find_with_move_unit import ufm_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [23:0]       i_s_axis_tdata,   // elem_a[10:0], elem_b[21:11], zero pad
    input  logic [TYPE_W-1:0] i_s_axis_tuser,   // req_type[1:0]
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata    // set_size[10:0], set_sum[30:11], zero pad
);

    t_node_req         alias_req, parent_req;
    t_size_req         size_req;
    t_sum_req          sum_req;
    t_node             alias_q, parent_q;
    logic [SIZE_W-1:0] size_q;
    logic [SUM_W-1:0]  sum_q;
    logic              res_valid, res_ready;
    t_result           res;

    logic              r_out_valid;
    t_result           r_out;

    ufm_ram #(.DEPTH(TBL_DEPTH), .WIDTH(NODE_W)) u_alias_ram (
        .i_clk   (i_clk),
        .i_we    (alias_req.we),
        .i_waddr (alias_req.waddr),
        .i_wdata (alias_req.wdata),
        .i_raddr (alias_req.raddr),
        .o_rdata (alias_q)
    );

    ufm_ram #(.DEPTH(TBL_DEPTH), .WIDTH(NODE_W)) u_parent_ram (
        .i_clk   (i_clk),
        .i_we    (parent_req.we),
        .i_waddr (parent_req.waddr),
        .i_wdata (parent_req.wdata),
        .i_raddr (parent_req.raddr),
        .o_rdata (parent_q)
    );

    ufm_ram #(.DEPTH(TBL_DEPTH), .WIDTH(SIZE_W)) u_size_ram (
        .i_clk   (i_clk),
        .i_we    (size_req.we),
        .i_waddr (size_req.waddr),
        .i_wdata (size_req.wdata),
        .i_raddr (size_req.raddr),
        .o_rdata (size_q)
    );

    ufm_ram #(.DEPTH(TBL_DEPTH), .WIDTH(SUM_W)) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_req.we),
        .i_waddr (sum_req.waddr),
        .i_wdata (sum_req.wdata),
        .i_raddr (sum_req.raddr),
        .o_rdata (sum_q)
    );

    ufm_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_req_type   (i_s_axis_tuser),
        .i_elem_a     (i_s_axis_tdata[ELEM_W-1:0]),
        .i_elem_b     (i_s_axis_tdata[2*ELEM_W-1:ELEM_W]),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_alias_req  (alias_req),
        .i_alias_q    (alias_q),
        .o_parent_req (parent_req),
        .i_parent_q   (parent_q),
        .o_size_req   (size_req),
        .i_size_q     (size_q),
        .o_sum_req    (sum_req),
        .i_sum_q      (sum_q)
    );

    assign res_ready = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.set_sum, r_out.set_size};

endmodule

[hdl/ufm_chk.sv]
// Port-level checker for the union-find engine, bound to the top level.
module ufm_chk import ufm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic [23:0]       i_s_axis_tdata,
    input logic [TYPE_W-1:0] i_s_axis_tuser,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [31:0]       o_m_axis_tdata
);

    // A result waiting on the output is neither dropped nor changed.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> $stable(o_m_axis_tdata))
        else $error("result changed while stalled");

    // The queried element belongs to its own set, so size and sum are never zero; the pad bit stays clear.
    a_res_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> (o_m_axis_tdata[10:0] != 11'd0)
                            && (o_m_axis_tdata[30:11] != 20'd0)
                            && !o_m_axis_tdata[31])
        else $error("result has an empty set or a set pad bit");

    // The engine is not ready again in the cycle after it accepts an item.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("input taken again right after an item");

    // A new result only appears while the engine is working on an item.
    a_result_from_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_axis_tvalid) |-> !$past(o_s_axis_tready))
        else $error("result appeared while the engine was idle");

endmodule

bind union_find_with_move_unit ufm_chk u_ufm_chk (.*);
